// ----- design/gvm_pkg.sv -----
// Shared types, constants and the taper window table for the granular voice mixer.
// No dependencies; imported by every module of the block.
package gvm_pkg;

  localparam int VOICES       = 32;
  localparam int VIDX_W       = 5;
  localparam int CNT_W        = 6;
  localparam int SAMPLE_DEPTH = 65536;
  localparam int SADDR_W      = 16;
  localparam int WIN_DEPTH    = 1024;
  localparam int WIDX_W       = 10;
  localparam int FRAC_W       = 8;
  localparam int POS_W        = 24;
  localparam int WINC_W       = 25;
  localparam int LEN_W        = 20;
  localparam int STEP_W       = 16;
  localparam int NUM_W        = 28;
  localparam int FRAMES_W     = 17;
  localparam int SUM_W        = 22;
  localparam int OUT_W        = 21;

  localparam logic [1:0] CMD_TRIG  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_EXCEEDS = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [STEP_W-1:0] inc;
    logic [LEN_W-1:0]  rem;
    logic [POS_W-1:0]  wpos;
    logic [WINC_W-1:0] winc;
  } voice_t;

  typedef struct packed {
    logic       item_ld;
    logic       vcnt_clr;
    logic       vcnt_inc;
    logic       smp_wr;
    logic       clr_all;
    logic       div_go;
    logic       div_sel;
    logic       stat_ld;
    logic [1:0] stat_code;
    logic       rd_b;
    logic       cap_a;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       wb;
    logic       commit;
    logic       out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic busy_sel;
    logic vlast;
    logic zero_arg;
    logic exceeds;
    logic div_done;
  } dp_stat_t;

  typedef logic [15:0] win_rom_t [WIN_DEPTH];

  function automatic logic [63:0] taper(input logic [63:0] zin);
    logic [63:0] z, z2, inner, mid, s, w;
    z = (zin > 64'd32768) ? 64'd32768 : zin;
    z2 = (z * z) >> 15;
    inner = 64'd21023 - ((64'd2320 * z2) >> 15);
    mid = 64'd51472 - ((z2 * inner) >> 15);
    s = (z * mid) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    w = (s * s) >> 15;
    if (w > 64'd32768) w = 64'd32768;
    return w;
  endfunction

  function automatic win_rom_t build_window();
    win_rom_t    rom;
    logic [63:0] w;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (i < WIN_DEPTH / 4)
        w = taper((64'(i) << 17) / WIN_DEPTH);
      else if (i < 3 * (WIN_DEPTH / 4))
        w = 64'd32768;
      else
        w = taper((64'(WIN_DEPTH - i) << 17) / WIN_DEPTH);
      rom[i] = w[15:0];
    end
    return rom;
  endfunction

endpackage

// ----- design/gvm_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on gvm_pkg for widths.
module gvm_div import gvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [LEN_W-1:0]  den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  logic             busy;
  logic [4:0]       cnt;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dreg;
  logic [LEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dreg <= den;
      quo  <= num;
    end else if (busy) begin
      rem <= fits ? LEN_W'(trial - {1'b0, dreg}) : trial[LEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ----- design/gvm_dp.sv -----
// Datapath: voice state memory, sample memory, window table, divider and mix accumulator.
// Depends on gvm_pkg and gvm_div.
module gvm_dp import gvm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             dcmd,
  output dp_stat_t            dstat,
  input  logic [87:0]         s_tdata,
  input  logic                cfg_we,
  input  logic [FRAMES_W-1:0] cfg_data,
  output logic [31:0]         m_tdata,
  output logic [1:0]          m_tuser
);

  localparam win_rom_t WIN_ROM = build_window();

  logic [15:0]         start_q;
  logic [LEN_W-1:0]    length_q;
  logic [STEP_W-1:0]   step_q;
  logic [SADDR_W-1:0]  addr_q;
  logic [15:0]         value_q;
  logic [FRAMES_W-1:0] frames;
  logic [VOICES-1:0]   busy;
  logic [CNT_W-1:0]    count;
  logic [VIDX_W-1:0]   vcnt;
  logic [1:0]          stat;
  logic signed [SUM_W-1:0] sum;

  voice_t vmem [VOICES];
  voice_t vq;
  voice_t vnew;
  logic signed [15:0] smem [SAMPLE_DEPTH];
  logic signed [15:0] smp_q;
  logic               oob_q;
  logic [SADDR_W:0]   raddr;
  logic [15:0]        win_q;
  logic [15:0]        widx_full;
  logic [WIDX_W-1:0]  widx;

  logic signed [15:0] a_reg, b_reg;
  logic signed [24:0] p1, interp;
  logic signed [41:0] prod;
  logic [FRAC_W-1:0]  f;
  logic [LEN_W-1:0]   rem_next;

  logic              div_done;
  logic [NUM_W-1:0]  quo;
  logic [NUM_W-1:0]  dnum;
  logic [LEN_W-1:0]  dden;

  assign f = vq.pos[FRAC_W-1:0];

  // divider operands: range check first, then window increment
  assign dnum = dcmd.div_sel ? NUM_W'(WIN_DEPTH << FRAC_W) : {length_q, 8'd0};
  assign dden = dcmd.div_sel ? length_q : {4'd0, step_q};

  gvm_div u_div (
    .clk(clk), .rst(rst), .start(dcmd.div_go), .num(dnum), .den(dden),
    .done(div_done), .quo(quo)
  );

  assign dstat.busy_sel = busy[vcnt];
  assign dstat.vlast    = vcnt == VIDX_W'(VOICES - 1);
  assign dstat.zero_arg = (length_q == '0) || (step_q == '0);
  assign dstat.exceeds  = ({13'd0, start_q} + {1'b0, quo}) > {12'd0, frames};
  assign dstat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames <= 17'h10000;
    end else if (cfg_we) begin
      frames <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.item_ld) begin
      start_q  <= s_tdata[15:0];
      length_q <= s_tdata[35:16];
      step_q   <= s_tdata[51:36];
      addr_q   <= s_tdata[67:52];
      value_q  <= s_tdata[83:68];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
    end else if (dcmd.vcnt_clr) begin
      vcnt <= '0;
    end else if (dcmd.vcnt_inc) begin
      vcnt <= vcnt + VIDX_W'(1);
    end
  end

  // voice state memory: read every cycle at the current voice
  always_comb begin
    rem_next = (vq.rem != '0) ? vq.rem - LEN_W'(1) : vq.rem;
    vnew = vq;
    if (dcmd.commit) begin
      vnew.pos  = {start_q, 8'd0};
      vnew.inc  = step_q;
      vnew.rem  = length_q;
      vnew.wpos = '0;
      vnew.winc = quo[WINC_W-1:0];
    end else begin
      vnew.pos  = vq.pos + POS_W'(vq.inc);
      vnew.wpos = POS_W'({1'b0, vq.wpos} + vq.winc);
      vnew.rem  = rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.commit || dcmd.wb) vmem[vcnt] <= vnew;
    vq <= vmem[vcnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      count <= '0;
    end else if (dcmd.clr_all) begin
      busy  <= '0;
      count <= '0;
    end else if (dcmd.commit) begin
      busy[vcnt] <= 1'b1;
      count      <= count + CNT_W'(1);
    end else if (dcmd.wb && rem_next == '0) begin
      busy[vcnt] <= 1'b0;
      count      <= count - CNT_W'(1);
    end
  end

  // sample memory: one read every cycle, plus one write when a sample write is commanded
  assign raddr = dcmd.rd_b ? {1'b0, vq.pos[POS_W-1:FRAC_W]} + 17'd1
                           : {1'b0, vq.pos[POS_W-1:FRAC_W]};

  always_ff @(posedge clk) begin
    if (dcmd.smp_wr) smem[addr_q] <= value_q;
    smp_q <= smem[raddr[SADDR_W-1:0]];
    oob_q <= raddr[SADDR_W];
  end

  assign widx_full = vq.wpos[POS_W-1:FRAC_W];
  assign widx = (widx_full >= 16'(WIN_DEPTH)) ? WIDX_W'(WIN_DEPTH - 1)
                                              : widx_full[WIDX_W-1:0];

  always_ff @(posedge clk) begin
    win_q <= WIN_ROM[widx];
  end

  always_ff @(posedge clk) begin
    if (dcmd.cap_a) a_reg <= oob_q ? 16'sd0 : smp_q;
    if (dcmd.mul1) begin
      b_reg <= oob_q ? 16'sd0 : smp_q;
      p1    <= 25'(a_reg * $signed({1'b0, 9'(9'd256 - {1'b0, f})}));
    end
    if (dcmd.mul2) interp <= p1 + 25'(b_reg * $signed({1'b0, f}));
    if (dcmd.mul3) prod <= 42'(interp * $signed({1'b0, win_q}));
  end

  always_ff @(posedge clk) begin
    if (dcmd.item_ld) begin
      sum  <= '0;
      stat <= ST_OK;
    end else begin
      if (dcmd.wb) sum <= sum + SUM_W'(prod >>> 23);
      if (dcmd.stat_ld) stat <= dcmd.stat_code;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.out_ld) begin
      m_tuser <= stat;
      if (sum > SUM_W'(1048575))
        m_tdata <= {5'd0, count, 21'h0FFFFF};
      else if (sum < -SUM_W'(1048576))
        m_tdata <= {5'd0, count, 21'h100000};
      else
        m_tdata <= {5'd0, count, sum[OUT_W-1:0]};
    end
  end

endmodule

// ----- design/gvm_ctrl.sv -----
// Sequencer: decodes each command and steps the datapath through it.
// Depends on gvm_pkg.
module gvm_ctrl import gvm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic [1:0] s_tuser,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dp_cmd_t  dcmd,
  input  dp_stat_t dstat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRT  = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_TCHK = 4'd7;
  localparam logic [3:0] S_TA   = 4'd8;
  localparam logic [3:0] S_TB   = 4'd9;
  localparam logic [3:0] S_TM1  = 4'd10;
  localparam logic [3:0] S_TM2  = 4'd11;
  localparam logic [3:0] S_TM3  = 4'd12;
  localparam logic [3:0] S_TWB  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state, state_next;
  logic       out_free;

  assign s_tready = state == S_IDLE;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (dcmd.out_ld) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    dcmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          dcmd.item_ld  = 1'b1;
          dcmd.vcnt_clr = 1'b1;
          unique case (s_tuser)
            CMD_TRIG:  state_next = S_SCAN;
            CMD_TICK:  state_next = S_TCHK;
            CMD_WRITE: state_next = S_WRT;
            CMD_CLEAR: state_next = S_CLR;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_WRT: begin
        dcmd.smp_wr = 1'b1;
        state_next  = S_OUT;
      end
      S_CLR: begin
        dcmd.clr_all = 1'b1;
        state_next   = S_OUT;
      end
      S_SCAN: begin
        if (!dstat.busy_sel) begin
          state_next = S_CHK;
        end else if (dstat.vlast) begin
          dcmd.stat_ld   = 1'b1;
          dcmd.stat_code = ST_NOFREE;
          state_next     = S_OUT;
        end else begin
          dcmd.vcnt_inc = 1'b1;
        end
      end
      S_CHK: begin
        if (dstat.zero_arg) begin
          dcmd.stat_ld   = 1'b1;
          dcmd.stat_code = ST_ZERO;
          state_next     = S_OUT;
        end else begin
          dcmd.div_go = 1'b1;
          state_next  = S_DIV1;
        end
      end
      S_DIV1: begin
        if (dstat.div_done) begin
          if (dstat.exceeds) begin
            dcmd.stat_ld   = 1'b1;
            dcmd.stat_code = ST_EXCEEDS;
            state_next     = S_OUT;
          end else begin
            dcmd.div_go  = 1'b1;
            dcmd.div_sel = 1'b1;
            state_next   = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (dstat.div_done) begin
          dcmd.commit = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_TCHK: begin
        if (dstat.busy_sel) begin
          state_next = S_TA;
        end else if (dstat.vlast) begin
          state_next = S_OUT;
        end else begin
          dcmd.vcnt_inc = 1'b1;
        end
      end
      S_TA: state_next = S_TB;
      S_TB: begin
        dcmd.rd_b  = 1'b1;
        dcmd.cap_a = 1'b1;
        state_next = S_TM1;
      end
      S_TM1: begin
        dcmd.mul1  = 1'b1;
        state_next = S_TM2;
      end
      S_TM2: begin
        dcmd.mul2  = 1'b1;
        state_next = S_TM3;
      end
      S_TM3: begin
        dcmd.mul3  = 1'b1;
        state_next = S_TWB;
      end
      S_TWB: begin
        dcmd.wb = 1'b1;
        if (dstat.vlast) begin
          state_next = S_OUT;
        end else begin
          dcmd.vcnt_inc = 1'b1;
          state_next    = S_TCHK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          dcmd.out_ld = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/granular_voice_mixer.sv -----
// Top level of the granular voice mixer: joins the sequencer and the datapath.
// Depends on gvm_pkg, gvm_ctrl, gvm_dp (and gvm_div below it).
//
// One command per input transaction, one result transaction per command. A tick walks all
// 32 voice slots one at a time: an idle slot is only checked, a busy slot goes through state
// read, two reads of the sample memory's single read port, three multiply stages and
// write-back. A trigger scans for the lowest free voice and runs two divisions with 28-bit
// quotients on a shared bit-serial divider; a sample write or clear goes straight on to
// its result.
// The next command is taken while the previous result still waits on the output.
// Sample memory has no reset; reading a sample that was never written gives undefined audio.
module granular_voice_mixer import gvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // grain_start, grain_length, grain_step, sample_addr, sample_value, zero pad
  input  logic [87:0] s_tdata,
  // cmd
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // audio_out, active_voices, zero pad
  output logic [31:0] m_tdata,
  // status
  output logic [1:0]  m_tuser,
  input  logic        cfg_we,
  // buffer_frames
  input  logic [16:0] cfg_data
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // sequence each command
  gvm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .dcmd(dcmd), .dstat(dstat)
  );

  // hold voices, samples and the mix
  gvm_dp u_dp (
    .clk(clk), .rst(rst),
    .dcmd(dcmd), .dstat(dstat),
    .s_tdata(s_tdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule
